/* design/jlab_pkg.sv */
// shared types, constants and helpers for the joint limit acceleration bounds block
package jlab_pkg;

   localparam int JOINTS      = 64;
   localparam int JOINT_BITS  = $clog2(JOINTS);
   localparam int WORD_W      = 32;
   localparam int NUM_W       = 81;   // |diff| << 17 fits in 81 bits
   localparam int DEN_W       = 64;
   localparam int QUOT_W      = 32;
   localparam int BOUND_W     = 35;   // signed, holds +-2^32 and its negation

   localparam logic [WORD_W-1:0] HORIZON_RESET = 32'd13107;
   localparam logic [QUOT_W:0]   QUOT_CAP      = {1'b1, {QUOT_W{1'b0}}};

   typedef enum logic {
      OP_WRITE   = 1'b0,
      OP_COMPUTE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_CHECK,
      DIV_ITER
   } div_phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL_H2,
      ST_MUL_VSQ,
      ST_HOR_START,
      ST_HOR_WAIT,
      ST_INF_START,
      ST_INF_WAIT,
      ST_COMBINE,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic            busy;
      logic [QUOT_W:0] quot;   // capped at 2^32
   } div_status_type;

   function automatic logic [WORD_W-1:0] sat32(input logic signed [BOUND_W-1:0] x);
      logic [WORD_W-1:0] r;
      if (x > $signed(35'sh0_7FFF_FFFF))
         r = 32'h7FFF_FFFF;
      else if (x < $signed(-35'sh0_8000_0000))
         r = 32'h8000_0000;
      else
         r = x[WORD_W-1:0];
      return r;
   endfunction

endpackage

/* design/jlab_limit_mem.sv */
// limit table memory: {upper, lower} per joint, one write and one registered read port
module jlab_limit_mem (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic                           rd_en,
   input  logic [jlab_pkg::JOINT_BITS-1:0] addr,
   input  logic [2*jlab_pkg::WORD_W-1:0]  wr_data,
   output logic [2*jlab_pkg::WORD_W-1:0]  rd_data
);
   import jlab_pkg::*;

   logic [2*WORD_W-1:0] mem_ff [JOINTS];
   logic [2*WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/jlab_div.sv */
// restoring long divider, 32 quotient bits after one overflow check, capped at 2^32
module jlab_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [jlab_pkg::NUM_W-1:0]     dividend,
   input  logic [jlab_pkg::DEN_W-1:0]     divisor,
   output jlab_pkg::div_status_type       status
);
   import jlab_pkg::*;

   div_phase_type     phase_ff, phase_in;
   logic [NUM_W-1:0]  num_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [QUOT_W-1:0] low_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic              over_ff;
   logic [4:0]        cnt_ff;

   logic [NUM_W-QUOT_W-1:0] upper;
   logic                    over_c;
   logic [DEN_W:0]          trial;
   logic                    fits;
   logic [DEN_W:0]          trial_sub;

   assign upper     = num_ff[NUM_W-1:QUOT_W];
   assign over_c    = {{(DEN_W-(NUM_W-QUOT_W)){1'b0}}, upper} >= den_ff;
   assign trial     = {rem_ff, low_ff[QUOT_W-1]};
   assign fits      = trial >= {1'b0, den_ff};
   assign trial_sub = trial - {1'b0, den_ff};

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         DIV_IDLE:  if (start) phase_in = DIV_CHECK;
         DIV_CHECK: phase_in = over_c ? DIV_IDLE : DIV_ITER;
         DIV_ITER:  if (cnt_ff == 5'd0) phase_in = DIV_IDLE;
         default:   phase_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= DIV_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      case (phase_ff)
         DIV_IDLE: begin
            if (start) begin
               num_ff <= dividend;
               den_ff <= divisor;
            end
         end
         DIV_CHECK: begin
            over_ff <= over_c;
            rem_ff  <= DEN_W'(upper);
            low_ff  <= num_ff[QUOT_W-1:0];
            quot_ff <= '0;
            cnt_ff  <= 5'(QUOT_W - 1);
         end
         DIV_ITER: begin
            rem_ff  <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            low_ff  <= {low_ff[QUOT_W-2:0], 1'b0};
            quot_ff <= {quot_ff[QUOT_W-2:0], fits};
            cnt_ff  <= cnt_ff - 5'd1;
         end
         default: begin
         end
      endcase
   end

   // status outputs
   always_comb begin
      status.busy = (phase_ff != DIV_IDLE);
      status.quot = over_ff ? QUOT_CAP : {1'b0, quot_ff};
   end

endmodule

/* design/joint_limit_accel_bounds_top.sv */
// top level: joint limit acceleration bounds with limit table, multiplier steps and dividers
//
// Keeps lower and upper position limits for 64 joints in one synchronous memory and
// answers compute items with the horizon acceleration bound 2*(X-p-h*v)/h^2 toward
// each limit, tightened by the inflection bound v^2/(2*(p-X)) when the time to the
// limit falls inside the horizon. Results are signed Q16.16 and saturate. Write items
// are taken while the block is idle. A compute item goes through one memory read, three
// 32x32 multiplier steps, then two divider passes (horizon, then inflection), each an
// overflow check plus 32 restoring steps and a wait to see both dividers done; the
// upper and lower side each own a divider and run side by side. A pass in which both
// dividers hit the cap ends after the overflow check, and an inflection pass that no
// side needs is skipped. Output stalls hold the finished item back. Only one compute
// item is in flight; a finished item waits in the output register while the next item
// is taken. A horizon write of zero is ignored.
module joint_limit_accel_bounds_top (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [5:0]  req_joint_index,
   input  logic [31:0] req_lower_limit,
   input  logic [31:0] req_upper_limit,
   input  logic [31:0] req_position,
   input  logic [31:0] req_velocity,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_joint_out,
   output logic [31:0] rsp_max_accel_bound,
   output logic [31:0] rsp_neg_min_accel_bound,
   // horizon register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_horizon
);
   import jlab_pkg::*;

   state_type state_ff, state_in;

   // horizon register
   logic [WORD_W-1:0] horizon_ff;

   // item context
   logic [JOINT_BITS-1:0]   joint_ff;
   logic signed [WORD_W-1:0] pos_ff;
   logic signed [WORD_W-1:0] vel_ff;
   logic [WORD_W-1:0]        vmag_ff;

   // multiplier products
   logic signed [2*WORD_W:0] prod_ff;   // h*v
   logic [2*WORD_W-1:0]      h2_ff;
   logic [2*WORD_W-1:0]      vsq_ff;
   logic [2*WORD_W-1:0]      hvmag_ff;

   // per side: gap X-p, horizon numerator, flags
   logic signed [WORD_W:0]     gap_u_ff, gap_l_ff;
   logic signed [2*WORD_W+1:0] diff_u_ff, diff_l_ff;
   logic neg_u_ff, neg_l_ff;
   logic win_u_ff, win_l_ff;
   logic need_u_ff, need_l_ff;
   logic [QUOT_W:0] hq_u_ff, hq_l_ff;
   logic signed [BOUND_W-1:0] maxv_ff, negmin_ff;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [JOINT_BITS-1:0] rsp_joint_ff;
   logic [WORD_W-1:0]     rsp_max_ff, rsp_negmin_ff;

   // control
   logic req_accept, out_free, push;
   logic mem_wr, mem_rd;
   logic div_start_u, div_start_l;
   logic [2*WORD_W-1:0] mem_rd_data;
   logic [NUM_W-1:0]    num_u, num_l;
   logic [DEN_W-1:0]    den_u, den_l;
   div_status_type      div_u, div_l;

   // side arithmetic
   logic [2*WORD_W+1:0] dmag_u, dmag_l;
   logic [WORD_W:0]     gmag_u, gmag_l;
   logic                win_u_c, win_l_c;
   logic signed [BOUND_W-1:0] hor_u, hor_l, lim_u, lim_l, maxv_c, minv_c;

   assign csr_ready  = 1'b1;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign push       = (state_ff == ST_PUSH) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_accept && req_opcode == OP_COMPUTE) state_in = ST_READ;
         ST_READ:      state_in = ST_MUL_H2;
         ST_MUL_H2:    state_in = ST_MUL_VSQ;
         ST_MUL_VSQ:   state_in = ST_HOR_START;
         ST_HOR_START: state_in = ST_HOR_WAIT;
         ST_HOR_WAIT:  if (!div_u.busy && !div_l.busy) state_in = ST_INF_START;
         ST_INF_START: state_in = ST_INF_WAIT;
         ST_INF_WAIT:  if (!div_u.busy && !div_l.busy) state_in = ST_COMBINE;
         ST_COMBINE:   state_in = ST_PUSH;
         ST_PUSH:      if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      mem_wr      = req_accept && req_opcode == OP_WRITE;
      mem_rd      = req_accept && req_opcode == OP_COMPUTE;
      div_start_u = (state_ff == ST_HOR_START) || (state_ff == ST_INF_START && need_u_ff);
      div_start_l = (state_ff == ST_HOR_START) || (state_ff == ST_INF_START && need_l_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         horizon_ff   <= HORIZON_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready && csr_horizon != '0) begin
            horizon_ff <= csr_horizon;
         end
      end
   end

   assign rsp_valid_in = push || (rsp_valid_ff && rsp_stall);

   jlab_limit_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .rd_en   (mem_rd),
      .addr    (req_joint_index),
      .wr_data ({req_upper_limit, req_lower_limit}),
      .rd_data (mem_rd_data)
   );

   // magnitudes and window test, both sides
   always_comb begin
      dmag_u  = diff_u_ff[2*WORD_W+1] ? 66'(-diff_u_ff) : 66'(diff_u_ff);
      dmag_l  = diff_l_ff[2*WORD_W+1] ? 66'(-diff_l_ff) : 66'(diff_l_ff);
      gmag_u  = gap_u_ff[WORD_W] ? 33'(-gap_u_ff) : 33'(gap_u_ff);
      gmag_l  = gap_l_ff[WORD_W] ? 33'(-gap_l_ff) : 33'(gap_l_ff);
      // time to the limit within [0, h]: same direction and 2*|gap| <= h*|v|
      win_u_c = (vel_ff != '0) && (gap_u_ff == '0 || gap_u_ff[WORD_W] == vel_ff[WORD_W-1])
                && ({14'b0, gmag_u, 17'b0} <= hvmag_ff);
      win_l_c = (vel_ff != '0) && (gap_l_ff == '0 || gap_l_ff[WORD_W] == vel_ff[WORD_W-1])
                && ({14'b0, gmag_l, 17'b0} <= hvmag_ff);
   end

   // divider operands: horizon pass, then inflection pass
   always_comb begin
      if (state_ff == ST_HOR_START) begin
         num_u = {dmag_u[2*WORD_W-1:0], 17'b0};
         num_l = {dmag_l[2*WORD_W-1:0], 17'b0};
         den_u = h2_ff;
         den_l = h2_ff;
      end else begin
         num_u = NUM_W'(vsq_ff);
         num_l = NUM_W'(vsq_ff);
         den_u = {30'b0, gmag_u, 1'b0};
         den_l = {30'b0, gmag_l, 1'b0};
      end
   end

   jlab_div u_div_upper (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_u),
      .dividend (num_u),
      .divisor  (den_u),
      .status   (div_u)
   );

   jlab_div u_div_lower (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_l),
      .dividend (num_l),
      .divisor  (den_l),
      .status   (div_l)
   );

   // combine horizon and inflection bounds
   always_comb begin
      hor_u = neg_u_ff ? -$signed({2'b0, hq_u_ff}) : $signed({2'b0, hq_u_ff});
      hor_l = neg_l_ff ? -$signed({2'b0, hq_l_ff}) : $signed({2'b0, hq_l_ff});
      // zero gap means +infinity; positive gap flips the sign of v^2/(2|gap|)
      if (gap_u_ff == '0)
         lim_u = $signed({2'b0, QUOT_CAP});
      else if (!gap_u_ff[WORD_W])
         lim_u = -$signed({2'b0, div_u.quot});
      else
         lim_u = $signed({2'b0, div_u.quot});
      if (gap_l_ff == '0)
         lim_l = $signed({2'b0, QUOT_CAP});
      else if (!gap_l_ff[WORD_W])
         lim_l = -$signed({2'b0, div_l.quot});
      else
         lim_l = $signed({2'b0, div_l.quot});
      maxv_c = (win_u_ff && hor_u >= lim_u) ? lim_u : hor_u;
      minv_c = (win_l_ff && hor_l <= lim_l) ? lim_l : hor_l;
   end

   // datapath sequencing
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (mem_rd) begin
               joint_ff <= req_joint_index;
               pos_ff   <= req_position;
               vel_ff   <= req_velocity;
               vmag_ff  <= req_velocity[WORD_W-1] ? 32'(-req_velocity) : req_velocity;
            end
         end
         ST_READ: begin
            prod_ff  <= $signed({1'b0, horizon_ff}) * vel_ff;
            gap_u_ff <= $signed({mem_rd_data[2*WORD_W-1], mem_rd_data[2*WORD_W-1:WORD_W]})
                        - $signed({pos_ff[WORD_W-1], pos_ff});
            gap_l_ff <= $signed({mem_rd_data[WORD_W-1], mem_rd_data[WORD_W-1:0]})
                        - $signed({pos_ff[WORD_W-1], pos_ff});
         end
         ST_MUL_H2: begin
            h2_ff <= horizon_ff * horizon_ff;
         end
         ST_MUL_VSQ: begin
            vsq_ff    <= vmag_ff * vmag_ff;
            hvmag_ff  <= prod_ff[2*WORD_W] ? 64'(-prod_ff) : prod_ff[2*WORD_W-1:0];
            diff_u_ff <= $signed({{17{gap_u_ff[WORD_W]}}, gap_u_ff, 16'b0}) - prod_ff;
            diff_l_ff <= $signed({{17{gap_l_ff[WORD_W]}}, gap_l_ff, 16'b0}) - prod_ff;
         end
         ST_HOR_START: begin
            neg_u_ff  <= diff_u_ff[2*WORD_W+1];
            neg_l_ff  <= diff_l_ff[2*WORD_W+1];
            win_u_ff  <= win_u_c;
            win_l_ff  <= win_l_c;
            need_u_ff <= win_u_c && gap_u_ff != '0;
            need_l_ff <= win_l_c && gap_l_ff != '0;
         end
         ST_HOR_WAIT: begin
            if (!div_u.busy && !div_l.busy) begin
               hq_u_ff <= div_u.quot;
               hq_l_ff <= div_l.quot;
            end
         end
         ST_COMBINE: begin
            maxv_ff   <= maxv_c;
            negmin_ff <= -minv_c;
         end
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (push) begin
         rsp_joint_ff  <= joint_ff;
         rsp_max_ff    <= sat32(maxv_ff);
         rsp_negmin_ff <= sat32(negmin_ff);
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_joint_out           = rsp_joint_ff;
   assign rsp_max_accel_bound     = rsp_max_ff;
   assign rsp_neg_min_accel_bound = rsp_negmin_ff;

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the joint limit acceleration bounds block
`timescale 1ns / 1ps

module tb_top;
   import jlab_pkg::*;

   localparam int IDLE_PCT   = 36;
   localparam int STALL_MAX  = 20000;   // cycles with no handshake before giving up
   localparam int DRAIN_WAIT = 200;     // settle time after every expected result is back

   typedef struct {
      opcode_type  op;
      logic [5:0]  joint;
      logic [31:0] lo;
      logic [31:0] up;
      logic [31:0] pos;
      logic [31:0] vel;
   } joint_item_type;

   typedef struct {
      logic [5:0]  joint;
      logic [31:0] max_b;
      logic [31:0] neg_min_b;
   } bounds_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_opcode = 1'b0;
   logic [5:0]  req_joint_index = '0;
   logic [31:0] req_lower_limit = '0;
   logic [31:0] req_upper_limit = '0;
   logic [31:0] req_position = '0;
   logic [31:0] req_velocity = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_joint_out;
   logic [31:0] rsp_max_accel_bound;
   logic [31:0] rsp_neg_min_accel_bound;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_horizon = '0;

   joint_limit_accel_bounds_top u_top (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_opcode              (req_opcode),
      .req_joint_index         (req_joint_index),
      .req_lower_limit         (req_lower_limit),
      .req_upper_limit         (req_upper_limit),
      .req_position            (req_position),
      .req_velocity            (req_velocity),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_joint_out           (rsp_joint_out),
      .rsp_max_accel_bound     (rsp_max_accel_bound),
      .rsp_neg_min_accel_bound (rsp_neg_min_accel_bound),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_horizon             (csr_horizon)
   );

   // 4 ns clock
   initial begin
      forever #2 clock = ~clock;
   end

   // shadow copy of the block state
   logic [31:0] horizon_q = HORIZON_RESET;
   logic [31:0] lower_tab [JOINTS];
   logic [31:0] upper_tab [JOINTS];
   bit          limits_set [JOINTS];   // generator side: joint written at least once

   joint_item_type pending_items[$];
   bounds_type     expected_bounds[$];

   bit req_taken  = 1'b0;
   bit hold_items = 1'b0;   // sender pause
   bit calm       = 1'b0;   // no idling on either side
   int mismatches = 0;
   int quiet_cycles = 0;

   // ------------------------------------------------------------------
   // bound arithmetic, exact in wide integers
   // ------------------------------------------------------------------

   // floor(num/den), capped at 2^32
   function automatic longint capped_quot(logic [127:0] num, logic [127:0] den);
      logic [127:0] q;
      q = num / den;
      if (q >= 128'h1_0000_0000)
         return 64'sh1_0000_0000;
      return longint'(q[32:0]);
   endfunction

   // 2*(X-p-h*v)/h^2
   function automatic longint horizon_accel(longint lim, longint p, longint v);
      longint hz;
      logic signed [127:0] diff;
      logic [127:0] mag;
      longint q;
      hz = longint'(horizon_q);
      diff = (lim - p) * 64'sd65536;
      diff = diff - hz * v;
      mag = (diff < 0) ? 128'(-diff) : 128'(diff);
      q = capped_quot(mag << 17, 128'(hz) * 128'(hz));
      return (diff < 0) ? -q : q;
   endfunction

   // time to the limit 2*gap/v inside [0, h]
   function automatic bit limit_in_reach(longint gap, longint v);
      logic [127:0] mg, mv;
      if (v == 0)
         return 1'b0;
      if (gap != 0 && ((gap > 0) != (v > 0)))
         return 1'b0;
      mg = (gap < 0) ? 128'(-gap) : 128'(gap);
      mv = (v < 0) ? 128'(-v) : 128'(v);
      return (mg << 17) <= 128'(horizon_q) * mv;
   endfunction

   // v^2/(2*(p-X)), zero gap is +infinity
   function automatic longint inflection_accel(longint gap, longint v);
      logic [127:0] mg, mv;
      longint q;
      if (gap == 0)
         return 64'sh1_0000_0000;
      mg = (gap < 0) ? 128'(-gap) : 128'(gap);
      mv = (v < 0) ? 128'(-v) : 128'(v);
      q = capped_quot(mv * mv, 2 * mg);
      return (gap > 0) ? -q : q;
   endfunction

   function automatic logic [31:0] clamp_q16(longint x);
      if (x > 64'sd2147483647)
         return 32'h7FFF_FFFF;
      if (x < -64'sd2147483648)
         return 32'h8000_0000;
      return x[31:0];
   endfunction

   function automatic bounds_type joint_bounds(joint_item_type it);
      bounds_type r;
      longint p, v, lo, up, hi_b, lo_b, alt;
      p  = longint'($signed(it.pos));
      v  = longint'($signed(it.vel));
      lo = longint'($signed(lower_tab[it.joint]));
      up = longint'($signed(upper_tab[it.joint]));
      hi_b = horizon_accel(up, p, v);
      if (limit_in_reach(up - p, v)) begin
         alt = inflection_accel(up - p, v);
         if (hi_b >= alt)
            hi_b = alt;
      end
      lo_b = horizon_accel(lo, p, v);
      if (limit_in_reach(lo - p, v)) begin
         alt = inflection_accel(lo - p, v);
         if (lo_b <= alt)
            lo_b = alt;
      end
      r.joint     = it.joint;
      r.max_b     = clamp_q16(hi_b);
      r.neg_min_b = clamp_q16(-lo_b);
      return r;
   endfunction

   // ------------------------------------------------------------------
   // driver: new item at the falling edge once the last one was taken
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      joint_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
         if (!req_valid || req_taken) begin
            if (pending_items.size() > 0 && !hold_items &&
                (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               it = pending_items.pop_front();
               req_opcode      <= it.op;
               req_joint_index <= it.joint;
               req_lower_limit <= it.lo;
               req_upper_limit <= it.up;
               req_position    <= it.pos;
               req_velocity    <= it.vel;
               req_valid       <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // acceptance, prediction and result check at the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      joint_item_type it;
      bounds_type exp_b;
      bit active;
      active = 1'b0;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         // accepted input item
         if (req_valid && !req_stall) begin
            active = 1'b1;
            it.op    = opcode_type'(req_opcode);
            it.joint = req_joint_index;
            it.lo    = req_lower_limit;
            it.up    = req_upper_limit;
            it.pos   = req_position;
            it.vel   = req_velocity;
            if (it.op == OP_WRITE) begin
               lower_tab[it.joint] = it.lo;
               upper_tab[it.joint] = it.up;
            end else begin
               expected_bounds.push_back(joint_bounds(it));
            end
         end
         // horizon register write, zero is ignored
         if (csr_valid && csr_ready) begin
            active = 1'b1;
            if (csr_horizon != 0)
               horizon_q = csr_horizon;
         end
         // result item
         if (rsp_valid && !rsp_stall) begin
            active = 1'b1;
            if (expected_bounds.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: joint %0d max %h negmin %h", rsp_joint_out,
                           rsp_max_accel_bound, rsp_neg_min_accel_bound);
            end else begin
               exp_b = expected_bounds.pop_front();
               if (rsp_joint_out !== exp_b.joint || rsp_max_accel_bound !== exp_b.max_b ||
                   rsp_neg_min_accel_bound !== exp_b.neg_min_b) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp joint %0d max %h negmin %h, got %0d %h %h",
                              exp_b.joint, exp_b.max_b, exp_b.neg_min_b, rsp_joint_out,
                              rsp_max_accel_bound, rsp_neg_min_accel_bound);
               end
            end
         end
         // watchdog on handshake activity
         if (active)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_MAX) begin
            $display("joint_limit_accel_bounds_top test failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------

   // random value of random magnitude and sign
   function automatic logic [31:0] scaled_rand();
      logic [31:0] x;
      x = $urandom >> $urandom_range(0, 31);
      return $urandom_range(0, 1) ? -x : x;
   endfunction

   // generator side view of the tables: last write queued for the joint
   function automatic logic [31:0] upper_tab_gen(int j);
      for (int k = pending_items.size() - 1; k >= 0; k--)
         if (pending_items[k].op == OP_WRITE && pending_items[k].joint == j)
            return pending_items[k].up;
      return upper_tab[j];
   endfunction

   function automatic logic [31:0] lower_tab_gen(int j);
      for (int k = pending_items.size() - 1; k >= 0; k--)
         if (pending_items[k].op == OP_WRITE && pending_items[k].joint == j)
            return pending_items[k].lo;
      return lower_tab[j];
   endfunction

   task automatic add_item(opcode_type op, int j, logic [31:0] lo, logic [31:0] up,
                           logic [31:0] pos, logic [31:0] vel);
      joint_item_type it;
      it.op = op;
      it.joint = j[5:0];
      it.lo = lo;
      it.up = up;
      it.pos = pos;
      it.vel = vel;
      if (op == OP_WRITE)
         limits_set[j] = 1'b1;
      pending_items.push_back(it);
   endtask

   task automatic add_random();
      int j, mode;
      logic [31:0] lo, up, pos, vel, gap;
      j = $urandom_range(0, JOINTS - 1);
      mode = $urandom_range(0, 99);
      if (!limits_set[j] || mode < 25) begin
         if (mode < 8) begin
            lo = $urandom;
            up = $urandom;
         end else begin
            // well-formed limits, lower not above upper
            lo = scaled_rand();
            up = lo + ($urandom >> $urandom_range(1, 31));
            if ($signed(up) < $signed(lo))
               up = 32'h7FFF_FFFF;
         end
         add_item(OP_WRITE, j, lo, up, $urandom, $urandom);
      end else begin
         mode = $urandom_range(0, 99);
         if (mode < 15) begin
            pos = $urandom;
            vel = $urandom;
         end else begin
            // near one limit so the inflection test gets exercised
            gap = $urandom >> $urandom_range(4, 31);
            if ($urandom_range(0, 9) == 0)
               gap = 0;
            if ($urandom_range(0, 1)) begin
               pos = upper_tab_gen(j) - gap;
               vel = $urandom >> $urandom_range(0, 24);
            end else begin
               pos = lower_tab_gen(j) + gap;
               vel = -($urandom >> $urandom_range(0, 24));
            end
            if ($urandom_range(0, 4) == 0)
               vel = -vel;
            if ($urandom_range(0, 19) == 0)
               vel = 0;
         end
         add_item(OP_COMPUTE, j, $urandom, $urandom, pos, vel);
      end
   endtask

   // waits until every queued item is sent and every expected result is back, then lets the block settle
   task automatic wait_idle();
      while (pending_items.size() != 0 || req_valid || expected_bounds.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_horizon(logic [31:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_horizon = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      logic [31:0] horizons [5];
      horizons = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd65536, 32'd0};
      horizons[4] = $urandom_range(1, 32'h0004_0000);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extreme limits, zero gaps, zero velocity, extreme motion
      add_item(OP_WRITE, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
      add_item(OP_WRITE, 63, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_item(OP_WRITE, 1, 32'hFFFF_0000, 32'h0001_0000, 0, 0);
      add_item(OP_COMPUTE, 0, 0, 0, 32'h0000_0000, 32'h0000_0000);
      add_item(OP_COMPUTE, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_item(OP_COMPUTE, 0, 0, 0, 32'h8000_0000, 32'h8000_0000);
      add_item(OP_COMPUTE, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
      add_item(OP_COMPUTE, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
      add_item(OP_COMPUTE, 63, 0, 0, 32'h0000_0000, 32'h0000_0000);
      add_item(OP_COMPUTE, 63, 0, 0, 32'h0000_0000, 32'h0001_0000);
      add_item(OP_COMPUTE, 63, 0, 0, 32'h0000_0000, 32'hFFFF_0000);
      add_item(OP_COMPUTE, 1, 0, 0, 32'h0001_0000, 32'h0000_0000);
      add_item(OP_COMPUTE, 1, 0, 0, 32'h0000_F000, 32'h0004_0000);
      add_item(OP_COMPUTE, 1, 0, 0, 32'hFFFF_1000, 32'hFFFC_0000);
      add_item(OP_COMPUTE, 1, 0, 0, 32'h0000_0001, 32'h7FFF_FFFF);
      add_item(OP_COMPUTE, 1, 0, 0, 32'hFFFF_FFFF, 32'h8000_0000);
      add_item(OP_WRITE, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
      add_item(OP_COMPUTE, 1, 0, 0, 32'h0000_0000, 32'h0000_0001);
      add_item(OP_COMPUTE, 1, 0, 0, 32'h7FFF_FFFF, 32'h0000_0000);
      wait_idle();

      // random phases, each after a horizon write (a zero write is ignored), the first at reset value
      for (int ph = 0; ph <= 5; ph++) begin
         if (ph > 0)
            write_horizon(horizons[ph - 1]);
         calm = (ph == 2);
         for (int n = 0; n < 315; n++)
            add_random();
         wait_idle();
      end

      if (mismatches == 0 && expected_bounds.size() == 0)
         $display("joint_limit_accel_bounds_top test passed");
      else
         $display("joint_limit_accel_bounds_top test failed");
      $finish;
   end

endmodule
